// ===== design/u2r_pkg.sv =====
// Shared types, constants and arithmetic helpers for the UYVY to RGB converter.
package u2r_pkg;

   localparam int unsigned PixW   = 8;
   localparam int unsigned CoefW  = 12;
   localparam int unsigned FracW  = 11;
   localparam int unsigned ProdW  = 22;
   localparam int unsigned DeltaW = 10;
   localparam int unsigned SumW   = 12;

   localparam logic [PixW-1:0]  ChromaBias = 8'd128;
   localparam logic [PixW-1:0]  PixMax     = 8'd255;
   localparam logic [CoefW-1:0] KRv        = 12'd1434;
   localparam logic [CoefW-1:0] KBu        = 12'd2078;
   localparam logic [CoefW-1:0] KGu        = 12'd406;
   localparam logic [CoefW-1:0] KGv        = 12'd595;
   localparam logic [ProdW-1:0] FracRound  = ProdW'((1 << FracW) - 1);

   typedef struct packed {
      logic [PixW-1:0] chroma_u;
      logic [PixW-1:0] luma_first;
      logic [PixW-1:0] chroma_v;
      logic [PixW-1:0] luma_second;
   } group_type;

   typedef struct packed {
      logic [PixW-1:0] red_first;
      logic [PixW-1:0] green_first;
      logic [PixW-1:0] blue_first;
      logic [PixW-1:0] red_second;
      logic [PixW-1:0] green_second;
      logic [PixW-1:0] blue_second;
   } pixels_type;

   // trunc((chroma - 128) * k / 2048), rounded toward zero
   function automatic logic signed [DeltaW-1:0] chroma_term(
      input logic [PixW-1:0]  chroma,
      input logic [CoefW-1:0] k
   );
      logic signed [PixW:0]    c;
      logic signed [ProdW-1:0] prod;
      logic signed [ProdW-1:0] adj;
      c    = $signed({1'b0, chroma}) - $signed({1'b0, ChromaBias});
      prod = ProdW'(c) * $signed({{(ProdW - CoefW){1'b0}}, k});
      adj  = prod + (prod[ProdW-1] ? $signed(FracRound) : $signed(ProdW'(0)));
      return DeltaW'(adj >>> FracW);
   endfunction

   function automatic logic [PixW-1:0] sat8(input logic signed [SumW-1:0] x);
      if (x < 0) begin
         return '0;
      end else if (x > $signed({{(SumW - PixW){1'b0}}, PixMax})) begin
         return PixMax;
      end
      return x[PixW-1:0];
   endfunction

endpackage

// ===== design/u2r_if.sv =====
// Valid/ready channel interfaces for UYVY groups and RGB pixel pairs.
interface u2r_req_if;
   logic                    valid;
   logic                    ready;
   logic [u2r_pkg::PixW-1:0] chroma_u;
   logic [u2r_pkg::PixW-1:0] luma_first;
   logic [u2r_pkg::PixW-1:0] chroma_v;
   logic [u2r_pkg::PixW-1:0] luma_second;
   logic                    last_group;

   modport source (output valid, chroma_u, luma_first, chroma_v, luma_second, last_group,
                   input ready);
   modport sink   (input valid, chroma_u, luma_first, chroma_v, luma_second, last_group,
                   output ready);
endinterface

interface u2r_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [u2r_pkg::PixW-1:0] red_first;
   logic [u2r_pkg::PixW-1:0] green_first;
   logic [u2r_pkg::PixW-1:0] blue_first;
   logic [u2r_pkg::PixW-1:0] red_second;
   logic [u2r_pkg::PixW-1:0] green_second;
   logic [u2r_pkg::PixW-1:0] blue_second;
   logic                    last_out;

   modport source (output valid, red_first, green_first, blue_first,
                   red_second, green_second, blue_second, last_out,
                   input ready);
   modport sink   (input valid, red_first, green_first, blue_first,
                   red_second, green_second, blue_second, last_out,
                   output ready);
endinterface

// ===== design/u2r_color_math.sv =====
// Combinational YUV to RGB fixed-point math for one UYVY group.
module u2r_color_math (
   input  u2r_pkg::group_type  group_in,
   output u2r_pkg::pixels_type pixels_out
);

   logic signed [u2r_pkg::DeltaW-1:0] delta_r;
   logic signed [u2r_pkg::DeltaW-1:0] delta_b;
   logic signed [u2r_pkg::DeltaW-1:0] delta_gu;
   logic signed [u2r_pkg::DeltaW-1:0] delta_gv;
   logic signed [u2r_pkg::SumW-1:0]   luma0;
   logic signed [u2r_pkg::SumW-1:0]   luma1;
   logic signed [u2r_pkg::SumW-1:0]   off_sum;
   logic        [u2r_pkg::PixW-1:0]   off_sat;
   logic signed [u2r_pkg::SumW-1:0]   off_ext;

   always_comb begin
      delta_r  = u2r_pkg::chroma_term(group_in.chroma_v, u2r_pkg::KRv);
      delta_b  = u2r_pkg::chroma_term(group_in.chroma_u, u2r_pkg::KBu);
      delta_gu = u2r_pkg::chroma_term(group_in.chroma_u, u2r_pkg::KGu);
      delta_gv = u2r_pkg::chroma_term(group_in.chroma_v, u2r_pkg::KGv);
      luma0    = $signed({{(u2r_pkg::SumW - u2r_pkg::PixW){1'b0}}, group_in.luma_first});
      luma1    = $signed({{(u2r_pkg::SumW - u2r_pkg::PixW){1'b0}}, group_in.luma_second});
      off_sum  = u2r_pkg::SumW'(delta_gu) + u2r_pkg::SumW'(delta_gv);
      off_sat  = u2r_pkg::sat8(off_sum);
      off_ext  = $signed({{(u2r_pkg::SumW - u2r_pkg::PixW){1'b0}}, off_sat});

      pixels_out.red_first    = u2r_pkg::sat8(luma0 + u2r_pkg::SumW'(delta_r));
      pixels_out.green_first  = u2r_pkg::sat8(luma0 - off_ext);
      pixels_out.blue_first   = u2r_pkg::sat8(luma0 + u2r_pkg::SumW'(delta_b));
      pixels_out.red_second   = u2r_pkg::sat8(luma1 + u2r_pkg::SumW'(delta_r));
      pixels_out.green_second = u2r_pkg::sat8(luma1 - off_ext);
      pixels_out.blue_second  = u2r_pkg::sat8(luma1 + u2r_pkg::SumW'(delta_b));
   end

endmodule

// ===== design/uyvy_to_rgb_converter.sv =====
// Top level of the UYVY to RGB888 converter: input register, color math, result register.
//
// Usage:
//   req_chan carries one UYVY group per item (U, Y0, V, Y1 and a last-of-image
//   flag); rsp_chan carries one item per group: two RGB888 pixels sharing the
//   group's chroma, plus the copied last flag.
//   Both channels use valid/ready; an item moves on a clock edge with both high.
//   An accepted group waits in the input register, then passes through the color
//   math into the result register, which drives rsp_chan.
//   Throughput is one group per cycle while rsp_chan does not stall, set by the
//   two-register pipeline; each register refills in the same cycle that it empties.
//   When rsp_chan stalls, the result register holds, the input register holds
//   once it is also full, and req_chan.ready drops; no item is lost or repeated.
//   Synchronous reset empties both registers; no clearing pass is needed.
module uyvy_to_rgb_converter (
   input logic         clock,
   input logic         reset,
   u2r_req_if.sink     req_chan,
   u2r_rsp_if.source   rsp_chan
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   u2r_pkg::group_type  s1_group_ff;
   logic                s1_last_ff;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   u2r_pkg::pixels_type s2_pixels_ff;
   logic                s2_last_ff;
   u2r_pkg::pixels_type pixels;
   logic                s1_en;
   logic                s2_en;

   u2r_color_math u_math (
      .group_in   (s1_group_ff),
      .pixels_out (pixels)
   );

   assign s2_en          = !s2_valid_ff || rsp_chan.ready;
   assign s1_en          = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;
   assign s1_valid_in    = s1_en ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in    = s2_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_group_ff.chroma_u    <= req_chan.chroma_u;
         s1_group_ff.luma_first  <= req_chan.luma_first;
         s1_group_ff.chroma_v    <= req_chan.chroma_v;
         s1_group_ff.luma_second <= req_chan.luma_second;
         s1_last_ff              <= req_chan.last_group;
      end
      if (s2_en) begin
         s2_pixels_ff <= pixels;
         s2_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_chan.valid        = s2_valid_ff;
   assign rsp_chan.red_first    = s2_pixels_ff.red_first;
   assign rsp_chan.green_first  = s2_pixels_ff.green_first;
   assign rsp_chan.blue_first   = s2_pixels_ff.blue_first;
   assign rsp_chan.red_second   = s2_pixels_ff.red_second;
   assign rsp_chan.green_second = s2_pixels_ff.green_second;
   assign rsp_chan.blue_second  = s2_pixels_ff.blue_second;
   assign rsp_chan.last_out     = s2_last_ff;

   a_req_fill: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted item did not enter input register");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the input register");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_en) |=> (s1_valid_ff && $stable(s1_group_ff)))
      else $error("input register changed while stalled");

   a_last_follow: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_en) |=> (s2_valid_ff && s2_last_ff == $past(s1_last_ff)))
      else $error("last flag lost between stages");

endmodule

// ===== verif/u2r_color_checker.sv =====
`timescale 1ns / 100ps
// Checker for the UYVY to RGB converter: predicts each pixel pair and compares it.
module u2r_color_checker (
   input  logic clock,
   input  logic reset,
   u2r_req_if   req_mon,
   u2r_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending,
   output int   results_checked
);

   localparam int Bias     = 128;
   localparam int FracDiv  = 2048;
   localparam int ByteMax  = 255;
   localparam int PrintCap = 30;

   typedef struct packed {
      u2r_pkg::pixels_type pix;
      logic                last;
   } converted_pair_type;

   converted_pair_type expected_pairs[$];

   function automatic int scaled_chroma(input logic [u2r_pkg::PixW-1:0] chroma,
                                        input int coef);
      int centered;
      centered = int'(chroma) - Bias;
      return (centered * coef) / FracDiv;
   endfunction

   function automatic logic [u2r_pkg::PixW-1:0] clip_byte(input int x);
      if (x < 0) begin
         return '0;
      end else if (x > ByteMax) begin
         return u2r_pkg::PixW'(ByteMax);
      end
      return u2r_pkg::PixW'(x);
   endfunction

   function automatic converted_pair_type convert_group(input u2r_pkg::group_type g,
                                                        input logic last);
      converted_pair_type pair;
      int red_delta;
      int blue_delta;
      int green_offset;
      red_delta    = scaled_chroma(g.chroma_v, int'(u2r_pkg::KRv));
      blue_delta   = scaled_chroma(g.chroma_u, int'(u2r_pkg::KBu));
      green_offset = int'(clip_byte(scaled_chroma(g.chroma_u, int'(u2r_pkg::KGu))
                                    + scaled_chroma(g.chroma_v, int'(u2r_pkg::KGv))));
      pair.pix.red_first    = clip_byte(int'(g.luma_first) + red_delta);
      pair.pix.green_first  = clip_byte(int'(g.luma_first) - green_offset);
      pair.pix.blue_first   = clip_byte(int'(g.luma_first) + blue_delta);
      pair.pix.red_second   = clip_byte(int'(g.luma_second) + red_delta);
      pair.pix.green_second = clip_byte(int'(g.luma_second) - green_offset);
      pair.pix.blue_second  = clip_byte(int'(g.luma_second) + blue_delta);
      pair.last             = last;
      return pair;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PrintCap) begin
         $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      u2r_pkg::group_type group_in;
      converted_pair_type want;
      if (reset) begin
         expected_pairs.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            group_in.chroma_u    = req_mon.chroma_u;
            group_in.luma_first  = req_mon.luma_first;
            group_in.chroma_v    = req_mon.chroma_v;
            group_in.luma_second = req_mon.luma_second;
            expected_pairs.push_back(convert_group(group_in, req_mon.last_group));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_mon.red_first !== want.pix.red_first)
                  report_mismatch("red_first", int'(rsp_mon.red_first),
                                  int'(want.pix.red_first));
               if (rsp_mon.green_first !== want.pix.green_first)
                  report_mismatch("green_first", int'(rsp_mon.green_first),
                                  int'(want.pix.green_first));
               if (rsp_mon.blue_first !== want.pix.blue_first)
                  report_mismatch("blue_first", int'(rsp_mon.blue_first),
                                  int'(want.pix.blue_first));
               if (rsp_mon.red_second !== want.pix.red_second)
                  report_mismatch("red_second", int'(rsp_mon.red_second),
                                  int'(want.pix.red_second));
               if (rsp_mon.green_second !== want.pix.green_second)
                  report_mismatch("green_second", int'(rsp_mon.green_second),
                                  int'(want.pix.green_second));
               if (rsp_mon.blue_second !== want.pix.blue_second)
                  report_mismatch("blue_second", int'(rsp_mon.blue_second),
                                  int'(want.pix.blue_second));
               if (rsp_mon.last_out !== want.last)
                  report_mismatch("last_out", int'(rsp_mon.last_out), int'(want.last));
               results_checked <= results_checked + 1;
            end
         end
      end
      pending <= expected_pairs.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the UYVY to RGB converter: stimulus, result pacing and verdict.
module testbench;

   localparam int PhaseItems = 145;
   localparam int LongHold   = 60;
   localparam int StallLimit = 3000;
   localparam int Trailing   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_asked        = 0;
   int hold_done         = 0;
   int hold_left         = 0;
   int quiet_cycles      = 0;
   int groups_sent       = 0;
   int error_count;
   int pending;
   int results_checked;

   u2r_req_if req_chan ();
   u2r_rsp_if rsp_chan ();

   uyvy_to_rgb_converter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   u2r_color_checker color_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .error_count     (error_count),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer_group(input logic [u2r_pkg::PixW-1:0] u,
                              input logic [u2r_pkg::PixW-1:0] y0,
                              input logic [u2r_pkg::PixW-1:0] v,
                              input logic [u2r_pkg::PixW-1:0] y1,
                              input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.chroma_u    <= u;
      req_chan.luma_first  <= y0;
      req_chan.chroma_v    <= v;
      req_chan.luma_second <= y1;
      req_chan.last_group  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      groups_sent++;
   endtask

   function automatic logic [u2r_pkg::PixW-1:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(131, 125));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) begin
         offer_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(), $urandom_range(15) == 0);
      end
   endtask

   // hold off new items until every pixel pair is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [u2r_pkg::PixW-1:0] chroma_pts[3];
      chroma_pts = '{8'd0, 8'd128, 8'd255};
      req_chan.valid       <= 1'b0;
      req_chan.chroma_u    <= '0;
      req_chan.luma_first  <= '0;
      req_chan.chroma_v    <= '0;
      req_chan.luma_second <= '0;
      req_chan.last_group  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // chroma corners with black and white luma
      foreach (chroma_pts[i]) begin
         foreach (chroma_pts[j]) begin
            offer_group(chroma_pts[i], 8'd0, chroma_pts[j], 8'd255, 1'b0);
            offer_group(chroma_pts[i], 8'd255, chroma_pts[j], 8'd0, 1'b0);
         end
      end
      // truncation toward zero near the bias and further out, the last three flagged as last
      offer_group(8'd127, 8'd100, 8'd129, 8'd200, 1'b0);
      offer_group(8'd129, 8'd1, 8'd127, 8'd254, 1'b0);
      offer_group(8'd1, 8'd128, 8'd254, 8'd127, 1'b0);
      offer_group(8'd254, 8'd17, 8'd1, 8'd240, 1'b1);
      offer_group(8'd170, 8'd85, 8'd85, 8'd170, 1'b1);
      offer_group(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
      drain();

      sender_idle_pct   = 38;
      receiver_idle_pct = 86;
      send_random(PhaseItems);
      drain();

      sender_idle_pct   = 86;
      receiver_idle_pct = 38;
      send_random(PhaseItems);
      drain();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_asked++;
      send_random(PhaseItems);
      drain();

      repeat (Trailing) @(posedge clock);
      $display("Summary: %0d UYVY groups sent, %0d pixel pairs checked", groups_sent,
               results_checked);
      $display("Covered chroma and luma extremes, three idling mixes, a %0d-cycle result hold-off",
               LongHold);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
